// ----- rtl/legged_gait_sequencer_core_defines.svh -----
// Assertion macros shared by the gait sequencer checker
`ifndef LEGGED_GAIT_SEQUENCER_CORE_DEFINES_SVH
`define LEGGED_GAIT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define LGS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gait sequencer check failed");

// Next-cycle implication, checked on every clock edge outside reset
`define LGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gait sequencer check failed");

`endif

// ----- rtl/lgs_pkg.sv -----
// Types, constants and step table of the gait sequencer
package lgs_pkg;

    // Tick divider widths
    localparam int DIV_W      = 8;
    localparam int CNT_W      = DIV_W + 1;
    localparam int BIT_CNT_W  = $clog2(CNT_W);
    localparam int NUM_WALK   = 6;
    localparam int ITEM_CNT_W = 4;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_DIV = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DIV   = 1'd1;

    // Divisor reset values
    localparam logic [DIV_W-1:0] ROTATE_DIV_RESET = DIV_W'(2);
    localparam logic [DIV_W-1:0] SLOW_DIV_RESET   = DIV_W'(3);

    // Leg addresses
    localparam logic [1:0] LEG_LF = 2'd0;
    localparam logic [1:0] LEG_LB = 2'd1;
    localparam logic [1:0] LEG_RF = 2'd2;
    localparam logic [1:0] LEG_RB = 2'd3;

    typedef enum logic [2:0] {
        CMD_MID     = 3'd0,
        CMD_STRETCH = 3'd1,
        CMD_IN      = 3'd2,
        CMD_STEPMID = 3'd3,
        CMD_OUT     = 3'd4,
        CMD_INSIDE  = 3'd5,
        CMD_OUTSIDE = 3'd6
    } lgs_leg_cmd_t;

    typedef enum logic [2:0] {
        MODE_STAND      = 3'd0,
        MODE_FORWARD    = 3'd1,
        MODE_BACK       = 3'd2,
        MODE_LEFT       = 3'd3,
        MODE_RIGHT      = 3'd4,
        MODE_TURN_RIGHT = 3'd5,
        MODE_TURN_LEFT  = 3'd6
    } lgs_mode_t;

    typedef enum logic [1:0] {
        DSEL_ONE    = 2'd0,
        DSEL_SLOW   = 2'd1,
        DSEL_ROTATE = 2'd2
    } lgs_dsel_t;

    // Lead-in pattern emitted when a walking mode starts from phase zero, or the stand pattern outside walking
    typedef enum logic [2:0] {
        LEAD_NONE,
        LEAD_RIGHT_IN,
        LEAD_BACK_OUT,
        LEAD_FRONT_OUT,
        LEAD_STAND
    } lgs_lead_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_EMIT
    } lgs_state_t;

    typedef struct packed {
        logic              req_type;
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic              switch_left;
        logic              switch_right;
    } lgs_in_t;

    typedef struct packed {
        logic [1:0]   leg_index;
        lgs_leg_cmd_t leg_command;
        logic         last;
    } lgs_out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic joy_load;
        logic tick_inc;
        logic div_start;
        logic div_step;
        logic run_load;
        logic emit;
    } lgs_ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic plan_empty;
        logic emit_last;
        logic slot_free;
    } lgs_status_t;

    // Step command for one leg: step_sel 0 is the first step, 1 the second
    function automatic lgs_leg_cmd_t step_cmd(lgs_mode_t mode, logic step_sel,
                                              logic [1:0] leg);
        lgs_leg_cmd_t row [4];
        row = '{CMD_MID, CMD_MID, CMD_MID, CMD_MID};
        unique case (mode)
            MODE_FORWARD:
            begin
                if (step_sel) row = '{CMD_STEPMID, CMD_MID, CMD_INSIDE, CMD_IN};
                else          row = '{CMD_INSIDE, CMD_IN, CMD_STEPMID, CMD_MID};
            end
            MODE_BACK:
            begin
                if (step_sel) row = '{CMD_MID, CMD_STEPMID, CMD_IN, CMD_INSIDE};
                else          row = '{CMD_IN, CMD_INSIDE, CMD_MID, CMD_STEPMID};
            end
            MODE_LEFT:
            begin
                if (step_sel) row = '{CMD_STEPMID, CMD_OUTSIDE, CMD_MID, CMD_OUT};
                else          row = '{CMD_OUTSIDE, CMD_STEPMID, CMD_OUT, CMD_MID};
            end
            MODE_RIGHT:
            begin
                if (step_sel) row = '{CMD_OUT, CMD_MID, CMD_OUTSIDE, CMD_STEPMID};
                else          row = '{CMD_MID, CMD_OUT, CMD_STEPMID, CMD_OUTSIDE};
            end
            MODE_TURN_RIGHT:
            begin
                if (step_sel) row = '{CMD_MID, CMD_IN, CMD_IN, CMD_MID};
                else          row = '{CMD_OUT, CMD_MID, CMD_MID, CMD_OUT};
            end
            MODE_TURN_LEFT:
            begin
                if (step_sel) row = '{CMD_MID, CMD_OUT, CMD_OUT, CMD_MID};
                else          row = '{CMD_IN, CMD_MID, CMD_MID, CMD_IN};
            end
            default:
            begin
                row = '{CMD_MID, CMD_MID, CMD_MID, CMD_MID};
            end
        endcase
        return row[leg];
    endfunction

endpackage

// ----- rtl/lgs_ctrl.sv -----
// Controller state machine of the gait sequencer
module lgs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               req_type,
    output logic               in_ready,
    input  lgs_pkg::lgs_status_t sts,
    output lgs_pkg::lgs_ctrl_t   ctl
);
    import lgs_pkg::*;

    lgs_state_t state_reg;
    lgs_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && req_type) state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (sts.div_done) state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.rem_zero && !sts.plan_empty) state_next = ST_EMIT;
                else                                  state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sts.slot_free && sts.emit_last) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        ctl      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type)
                    begin
                        ctl.tick_inc  = 1'b1;
                        ctl.div_start = 1'b1;
                    end
                    else
                    begin
                        ctl.joy_load = 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                ctl.div_step = 1'b1;
            end
            ST_CHECK:
            begin
                ctl.run_load = sts.rem_zero;
            end
            ST_EMIT:
            begin
                ctl.emit = sts.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/lgs_datapath.sv -----
// Datapath: mode decode, tick divider, phase store and command emitter
module lgs_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lgs_pkg::lgs_ctrl_t              ctl,
    output lgs_pkg::lgs_status_t            sts,
    input  lgs_pkg::lgs_in_t                in_data,
    input  logic                            cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lgs_pkg::DIV_W-1:0]       cfg_wdata,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lgs_pkg::lgs_out_t               out_data
);
    import lgs_pkg::*;

    // Configuration and mode state
    logic [DIV_W-1:0] rotate_div_reg, rotate_div_next;
    logic [DIV_W-1:0] slow_div_reg, slow_div_next;
    lgs_mode_t        gait_mode_reg, gait_mode_next;
    lgs_dsel_t        dsel_reg, dsel_next;
    logic [CNT_W-1:0] tick_count_reg, tick_count_next;
    logic [1:0]       phase_reg [NUM_WALK];
    logic [1:0]       phase_next [NUM_WALK];

    // Remainder unit
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIV_W-1:0]     cur_div;
    logic [CNT_W-1:0]     rem_shift;

    // Latched plan of the current run
    lgs_lead_t             lead_reg, lead_next;
    lgs_mode_t             plan_mode_reg, plan_mode_next;
    logic                  step_sel_reg, step_sel_next;
    logic [ITEM_CNT_W-1:0] lead_cnt_reg, lead_cnt_next;
    logic [ITEM_CNT_W-1:0] total_reg, total_next;
    logic [ITEM_CNT_W-1:0] item_reg, item_next;

    // Output register
    logic     out_valid_reg, out_valid_next;
    lgs_out_t out_data_reg, out_data_next;

    // Combinational plan from the current mode and phase
    logic [2:0]            mode_bits;
    logic                  walking;
    logic [2:0]            walk_idx;
    logic [1:0]            cur_phase;
    lgs_lead_t             plan_lead;
    logic                  plan_step;
    logic                  plan_sel;
    logic [ITEM_CNT_W-1:0] plan_lead_cnt;
    logic [ITEM_CNT_W-1:0] plan_total;
    logic [1:0]            plan_phase [NUM_WALK];

    // Joystick decode
    logic signed [16:0] x_ext, y_ext, nx_ext, ny_ext;
    logic               stick_zero;
    logic               sec_forward, sec_left, sec_back;

    // Item generation
    lgs_out_t              item;
    logic [ITEM_CNT_W-1:0] step_pos;
    logic                  slot_free;

    // Decode the stick sector with exact comparisons
    always_comb
    begin
        x_ext       = {in_data.stick_x[15], in_data.stick_x};
        y_ext       = {in_data.stick_y[15], in_data.stick_y};
        nx_ext      = -x_ext;
        ny_ext      = -y_ext;
        stick_zero  = (in_data.stick_x == 16'sd0) && (in_data.stick_y == 16'sd0);
        sec_forward = (y_ext > 17'sd0) && (x_ext <= y_ext) && (x_ext > ny_ext);
        sec_left    = (x_ext < 17'sd0) && (y_ext <= nx_ext) && (y_ext > x_ext);
        sec_back    = (y_ext < 17'sd0) && (x_ext >= y_ext) && (x_ext < ny_ext);
    end

    // Select the active divisor, zero acting as one
    always_comb
    begin
        case (dsel_reg)
            DSEL_SLOW:   cur_div = slow_div_reg;
            DSEL_ROTATE: cur_div = rotate_div_reg;
            default:     cur_div = DIV_W'(1);
        endcase
        if (cur_div == '0) cur_div = DIV_W'(1);
    end

    // Shift in the next count bit for the restoring remainder
    assign rem_shift = {rem_reg[CNT_W-2:0], tick_count_reg[bit_cnt_reg]};

    // Work out what the current mode would emit on a run
    always_comb
    begin
        mode_bits = gait_mode_reg;
        walking   = (mode_bits >= MODE_FORWARD) && (mode_bits <= MODE_TURN_LEFT);
        walk_idx  = mode_bits - 3'd1;
        cur_phase = walking ? phase_reg[walk_idx] : 2'd0;
        plan_lead = LEAD_NONE;
        plan_step = 1'b0;
        plan_sel  = 1'b0;
        for (int i = 0; i < NUM_WALK; i++) plan_phase[i] = phase_reg[i];
        if (!walking)
        begin
            plan_lead = LEAD_STAND;
            for (int i = 0; i < NUM_WALK; i++) plan_phase[i] = 2'd0;
        end
        else
        begin
            case (cur_phase)
                2'd0:
                begin
                    for (int i = 0; i < NUM_WALK; i++) plan_phase[i] = 2'd0;
                    case (gait_mode_reg)
                        MODE_FORWARD, MODE_BACK: plan_lead = LEAD_RIGHT_IN;
                        MODE_LEFT:               plan_lead = LEAD_BACK_OUT;
                        MODE_RIGHT:              plan_lead = LEAD_FRONT_OUT;
                        default:                 plan_lead = LEAD_STAND;
                    endcase
                    if (gait_mode_reg == MODE_FORWARD)
                    begin
                        plan_phase[walk_idx] = 2'd1;
                    end
                    else
                    begin
                        plan_step            = 1'b1;
                        plan_phase[walk_idx] = 2'd2;
                    end
                end
                2'd1:
                begin
                    plan_step            = 1'b1;
                    plan_phase[walk_idx] = 2'd2;
                end
                2'd2:
                begin
                    plan_step            = 1'b1;
                    plan_sel             = 1'b1;
                    plan_phase[walk_idx] = 2'd1;
                end
                default:
                begin
                    plan_step = 1'b0;
                end
            endcase
        end
        case (plan_lead)
            LEAD_STAND: plan_lead_cnt = ITEM_CNT_W'(8);
            LEAD_NONE:  plan_lead_cnt = '0;
            default:    plan_lead_cnt = ITEM_CNT_W'(2);
        endcase
        plan_total = plan_lead_cnt + (plan_step ? ITEM_CNT_W'(4) : '0);
    end

    // Build the command at the current item position
    always_comb
    begin
        step_pos         = item_reg - lead_cnt_reg;
        item.last        = (item_reg == total_reg - ITEM_CNT_W'(1));
        item.leg_index   = LEG_LF;
        item.leg_command = CMD_MID;
        if (item_reg < lead_cnt_reg)
        begin
            case (lead_reg)
                LEAD_RIGHT_IN:
                begin
                    item.leg_index   = item_reg[0] ? LEG_RB : LEG_RF;
                    item.leg_command = CMD_IN;
                end
                LEAD_BACK_OUT:
                begin
                    item.leg_index   = item_reg[0] ? LEG_RB : LEG_LB;
                    item.leg_command = CMD_OUT;
                end
                LEAD_FRONT_OUT:
                begin
                    item.leg_index   = item_reg[0] ? LEG_RF : LEG_LF;
                    item.leg_command = CMD_OUT;
                end
                LEAD_STAND:
                begin
                    item.leg_index   = item_reg[2:1];
                    item.leg_command = item_reg[0] ? CMD_STRETCH : CMD_MID;
                end
                default:
                begin
                    item.leg_index   = LEG_LF;
                    item.leg_command = CMD_MID;
                end
            endcase
        end
        else
        begin
            item.leg_index   = step_pos[1:0];
            item.leg_command = step_cmd(plan_mode_reg, step_sel_reg, step_pos[1:0]);
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    // Next-state logic of all datapath registers
    always_comb
    begin
        rotate_div_next = rotate_div_reg;
        slow_div_next   = slow_div_reg;
        gait_mode_next  = gait_mode_reg;
        dsel_next       = dsel_reg;
        tick_count_next = tick_count_reg;
        for (int i = 0; i < NUM_WALK; i++) phase_next[i] = phase_reg[i];
        rem_next        = rem_reg;
        bit_cnt_next    = bit_cnt_reg;
        lead_next       = lead_reg;
        plan_mode_next  = plan_mode_reg;
        step_sel_next   = step_sel_reg;
        lead_cnt_next   = lead_cnt_reg;
        total_next      = total_reg;
        item_next       = item_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        // Take a register write
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROTATE_DIV: rotate_div_next = cfg_wdata;
                REG_SLOW_DIV:   slow_div_next   = cfg_wdata;
                default:        rotate_div_next = rotate_div_reg;
            endcase
        end

        // Take a joystick transaction
        if (ctl.joy_load)
        begin
            if (stick_zero && (in_data.switch_left == in_data.switch_right))
            begin
                dsel_next      = DSEL_ONE;
                gait_mode_next = MODE_STAND;
            end
            else if (in_data.switch_left && !in_data.switch_right)
            begin
                dsel_next      = DSEL_ROTATE;
                gait_mode_next = MODE_TURN_LEFT;
            end
            else if (!in_data.switch_left && in_data.switch_right)
            begin
                dsel_next      = DSEL_ROTATE;
                gait_mode_next = MODE_TURN_RIGHT;
            end
            else
            begin
                dsel_next = in_data.switch_left ? DSEL_SLOW : DSEL_ONE;
                if (sec_forward)   gait_mode_next = MODE_FORWARD;
                else if (sec_left) gait_mode_next = MODE_LEFT;
                else if (sec_back) gait_mode_next = MODE_BACK;
                else               gait_mode_next = MODE_RIGHT;
            end
        end

        // Count the tick and arm the remainder unit
        if (ctl.tick_inc) tick_count_next = tick_count_reg + CNT_W'(1);
        if (ctl.div_start)
        begin
            rem_next     = '0;
            bit_cnt_next = BIT_CNT_W'(CNT_W - 1);
        end

        // One restoring remainder step per cycle, most significant bit first
        if (ctl.div_step)
        begin
            if (rem_shift >= {1'b0, cur_div}) rem_next = rem_shift - {1'b0, cur_div};
            else                              rem_next = rem_shift;
            if (bit_cnt_reg != '0) bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
        end

        // Latch the plan, update phases and clear the tick count
        if (ctl.run_load)
        begin
            tick_count_next = '0;
            for (int i = 0; i < NUM_WALK; i++) phase_next[i] = plan_phase[i];
            lead_next      = plan_lead;
            plan_mode_next = gait_mode_reg;
            step_sel_next  = plan_sel;
            lead_cnt_next  = plan_lead_cnt;
            total_next     = plan_total;
            item_next      = '0;
        end

        // Load one command into the output register, or drop a taken one
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = item;
            item_next      = item_reg + ITEM_CNT_W'(1);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotate_div_reg <= ROTATE_DIV_RESET;
            slow_div_reg   <= SLOW_DIV_RESET;
            gait_mode_reg  <= MODE_STAND;
            dsel_reg       <= DSEL_ONE;
            tick_count_reg <= '0;
            for (int i = 0; i < NUM_WALK; i++) phase_reg[i] <= 2'd0;
            bit_cnt_reg    <= '0;
            item_reg       <= '0;
            total_reg      <= '0;
            lead_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rotate_div_reg <= rotate_div_next;
            slow_div_reg   <= slow_div_next;
            gait_mode_reg  <= gait_mode_next;
            dsel_reg       <= dsel_next;
            tick_count_reg <= tick_count_next;
            for (int i = 0; i < NUM_WALK; i++) phase_reg[i] <= phase_next[i];
            bit_cnt_reg    <= bit_cnt_next;
            item_reg       <= item_next;
            total_reg      <= total_next;
            lead_cnt_reg   <= lead_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        lead_reg      <= lead_next;
        plan_mode_reg <= plan_mode_next;
        step_sel_reg  <= step_sel_next;
        out_data_reg  <= out_data_next;
    end

    // Report status
    always_comb
    begin
        sts.div_done   = (bit_cnt_reg == '0);
        sts.rem_zero   = (rem_reg == '0);
        sts.plan_empty = (plan_total == '0);
        sts.emit_last  = item.last;
        sts.slot_free  = slot_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/legged_gait_sequencer_core.sv -----
// Sequencing: a joystick transaction is taken while idle and gives no result.
// A tick transaction is accepted while idle, runs through the shift-subtract
// remainder unit that tests the tick count against the divisor, and is then
// decided; a run then emits 2 to 12 leg commands, one per cycle while out_ready.
// One transaction is handled at a time; the next is taken only once it is done.
// Reset: asynchronous; divisors 2 and 3, stand mode, count and phases zero.
module legged_gait_sequencer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lgs_pkg::lgs_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lgs_pkg::lgs_out_t             out_data,
    input  logic                          cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lgs_pkg::DIV_W-1:0]     cfg_wdata
);
    import lgs_pkg::*;

    lgs_ctrl_t   ctl;
    lgs_status_t sts;

    // Sequence each transaction
    lgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_data.req_type),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Hold state and build leg commands
    lgs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/lgs_checker.sv -----
// Port-level checker of the gait sequencer, bound to the top level
`include "legged_gait_sequencer_core_defines.svh"

module lgs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input lgs_pkg::lgs_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input lgs_pkg::lgs_out_t out_data
);
    import lgs_pkg::*;

    // A stalled result holds its payload
    `LGS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // A joystick transaction raises no result
    `LGS_ASSERT_NEXT(a_joy_silent, in_valid && in_ready && !in_data.req_type, !$rose(out_valid))

    // No new transaction is taken while a run is still mid-way
    `LGS_ASSERT_NOW(a_busy_in_run, out_valid && !out_data.last, !in_ready)

    // Leg commands stay within the defined codes
    `LGS_ASSERT_NOW(a_cmd_range, out_valid, out_data.leg_command != 3'd7)

endmodule

bind legged_gait_sequencer_core lgs_checker u_lgs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
